@@ rtl/sha256_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values and controller/datapath command types.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int ROUND_COUNT  = 64;
  localparam int BLOCK_BYTES  = 64;
  localparam int DIGEST_WORDS = 8;
  localparam int BLOCK_WORDS  = BLOCK_BYTES / 4;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Controller to datapath commands.
  typedef struct packed {
    logic       load_word;   // store masked input word at fill position
    logic       last;        // the loaded word is the final one
    logic       pad;         // place 0x80 at the pad position
    logic       length;      // write bit count into words 14/15
    logic       start;       // copy hash into working registers
    logic       round;       // run one compression round
    logic       finish;      // fold working registers into hash
    logic       clear;       // return to the initial message state
  } sha256_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       block_full;  // loaded word filled the block
    logic       need_extra;  // pad position leaves no room for length
    logic       rounds_done; // round 63 is being executed
  } sha256_stat_t;

endpackage
`default_nettype wire

@@ rtl/sha256_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer with rolling schedule, one round per cycle, hash and length.
// ----------------------------------------------------------------------------
module sha256_datapath
  import sha256_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sha256_cmd_t  cmd,
  input  wire logic [31:0]  message_word,
  input  wire logic [2:0]   valid_bytes,
  input  wire logic [2:0]   out_sel,
  output sha256_stat_t      stat,
  output logic [31:0]       digest_word
);

  logic [31:0] hash [8];
  logic [31:0] work [8];
  logic [31:0] sched [16];
  logic [63:0] bit_count;
  logic [3:0]  word_fill;
  logic [5:0]  round_cnt;
  logic [5:0]  pad_pos;      // byte position of the pad marker
  logic        pad_wrap;     // marker goes into a fresh block

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Word masking and byte count for the incoming transaction.
  logic [2:0]  nbytes;
  logic [31:0] masked_word;
  logic [5:0]  bit_add;
  logic [6:0]  pos_raw;

  always_comb begin
    nbytes = 3'd4;
    if (cmd.last && valid_bytes < 3'd4) nbytes = valid_bytes;
    case (nbytes)
      3'd0:    masked_word = 32'h0;
      3'd1:    masked_word = message_word & 32'hff000000;
      3'd2:    masked_word = message_word & 32'hffff0000;
      3'd3:    masked_word = message_word & 32'hffffff00;
      default: masked_word = message_word;
    endcase
    bit_add = {nbytes, 3'b000};
    pos_raw = {1'b0, word_fill, 2'b00} + {4'd0, nbytes};
  end

  // Round logic.
  logic [3:0]  idx0, idx1, idx9, idx14;
  logic [31:0] x15, x2, s0, s1, w_new, wt, t1, t2;
  logic [31:0] ch, maj, e1, e0;

  always_comb begin
    idx0  = round_cnt[3:0];
    idx1  = round_cnt[3:0] + 4'd1;
    idx9  = round_cnt[3:0] + 4'd9;
    idx14 = round_cnt[3:0] + 4'd14;
    x15   = sched[idx1];
    x2    = sched[idx14];
    s0    = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    s1    = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    w_new = sched[idx0] + s0 + sched[idx9] + s1;
    wt    = (round_cnt >= 6'd16) ? w_new : sched[idx0];
    e1    = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    ch    = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1    = work[7] + e1 + ch + ROUND_K[round_cnt] + wt;
    e0    = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    maj   = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t2    = e0 + maj;
  end

  assign stat.block_full  = pos_raw[6];
  assign stat.need_extra  = pad_pos >= 6'd56;
  assign stat.rounds_done = round_cnt == 6'(ROUND_COUNT - 1);
  assign digest_word      = hash[out_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hash[i] <= INIT_HASH[i];
      for (int i = 0; i < 16; i++) sched[i] <= '0;
      bit_count <= '0;
      word_fill <= '0;
      round_cnt <= '0;
      pad_pos   <= '0;
      pad_wrap  <= 1'b0;
    end else begin
      if (cmd.load_word) begin
        sched[word_fill] <= masked_word;
        bit_count <= bit_count + {58'd0, bit_add};
        word_fill <= word_fill + 4'd1;
        pad_pos   <= pos_raw[5:0];
        pad_wrap  <= pos_raw[6];
      end
      if (cmd.pad) begin
        sched[pad_pos[5:2]] <= sched[pad_pos[5:2]] |
          ({24'd0, PAD_BYTE} << (6'd24 - {1'b0, pad_pos[1:0], 3'b000}));
      end
      if (cmd.length) begin
        sched[14] <= bit_count[63:32];
        sched[15] <= bit_count[31:0];
      end
      if (cmd.start) begin
        for (int i = 0; i < 8; i++) work[i] <= hash[i];
        round_cnt <= '0;
      end
      if (cmd.round) begin
        if (round_cnt >= 6'd16) sched[idx0] <= w_new;
        work[7] <= work[6];
        work[6] <= work[5];
        work[5] <= work[4];
        work[4] <= work[3] + t1;
        work[3] <= work[2];
        work[2] <= work[1];
        work[1] <= work[0];
        work[0] <= t1 + t2;
        round_cnt <= round_cnt + 6'd1;
      end
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + work[i];
        for (int i = 0; i < 16; i++) sched[i] <= '0;
        round_cnt <= '0;
        if (pad_wrap) begin
          pad_pos  <= '0;
          pad_wrap <= 1'b0;
        end
      end
      if (cmd.clear) begin
        for (int i = 0; i < 8; i++) hash[i] <= INIT_HASH[i];
        for (int i = 0; i < 16; i++) sched[i] <= '0;
        bit_count <= '0;
        word_fill <= '0;
        pad_pos   <= '0;
        pad_wrap  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/sha256_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word loads, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_sel,
  input  wire sha256_stat_t stat,
  output sha256_cmd_t       cmd
);

  typedef enum logic [2:0] {
    IDLE, START, ROUNDS, FINISH, PAD, LENGTH, EMIT
  } state_t;

  state_t state;
  logic   final_msg;   // a last word was taken; padding follows
  logic   pad_done;
  logic   len_done;
  logic   pend_pad;    // last word filled the block: pad after compress

  assign in_ready  = state == IDLE;
  assign out_valid = state == EMIT;

  always_comb begin
    cmd = '0;
    cmd.load_word = in_valid && in_ready;
    cmd.last      = in_last;
    cmd.pad       = state == PAD;
    cmd.length    = state == LENGTH;
    cmd.start     = state == START;
    cmd.round     = state == ROUNDS;
    cmd.finish    = state == FINISH;
    cmd.clear     = state == EMIT && out_ready && out_sel == 3'(DIGEST_WORDS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      final_msg <= 1'b0;
      pad_done  <= 1'b0;
      len_done  <= 1'b0;
      pend_pad  <= 1'b0;
      out_sel   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            final_msg <= in_last;
            pad_done  <= 1'b0;
            len_done  <= 1'b0;
            if (in_last) begin
              pend_pad <= stat.block_full;
              state    <= stat.block_full ? START : PAD;
            end else if (stat.block_full) begin
              state <= START;
            end
          end
        end
        PAD: begin
          pad_done <= 1'b1;
          // no room for the length: compress this block first
          state    <= stat.need_extra ? START : LENGTH;
        end
        LENGTH: begin
          len_done <= 1'b1;
          state    <= START;
        end
        START:  state <= ROUNDS;
        ROUNDS: if (stat.rounds_done) state <= FINISH;
        FINISH: begin
          if (!final_msg)     state <= IDLE;
          else if (len_done)  state <= EMIT;
          else if (pend_pad) begin
            pend_pad <= 1'b0;
            state    <= PAD;
          end else if (pad_done) state <= LENGTH;
          else state <= PAD;
        end
        EMIT: begin
          if (out_ready) begin
            out_sel <= out_sel + 3'd1;
            if (out_sel == 3'(DIGEST_WORDS - 1)) begin
              final_msg <= 1'b0;
              state     <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/sha256_hash_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streams 32-bit big-endian message words in, emits eight digest words.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                 | tuser         | tlast
// s_axis  | in  | [31:0] message_word   | [2:0] valid_bytes | last_word
// m_axis  | out | [31:0] digest_word    | [2:0] word_index  | last_digest
//
// A non-final word that does not complete a block is taken while the engine
// is idle; a word that completes a block starts the 64-round compression (one
// round per cycle). The final word adds padding and one or two compressions,
// then eight output beats. Input stalls while a block is padded or compressed
// or the digest is emitted. Reset loads the initial hash values.
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // message_word
  input  wire logic [2:0]  s_axis_tuser,   // valid_bytes
  input  wire logic        s_axis_tlast,   // last_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word
  output logic [2:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast    // last_digest
);

  sha256_cmd_t  cmd;
  sha256_stat_t stat;
  logic [2:0]   out_sel;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sel   (out_sel),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha256_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_word (s_axis_tdata),
    .valid_bytes  (s_axis_tuser),
    .out_sel      (out_sel),
    .stat         (stat),
    .digest_word  (m_axis_tdata)
  );

  assign m_axis_tuser = out_sel;
  assign m_axis_tlast = out_sel == 3'(DIGEST_WORDS - 1);

endmodule
`default_nettype wire

@@ tb/sv/tb_sha256_hash_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Streams directed and random messages into the engine and checks every
// digest word against a behavioral SHA-256 digest predictor.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine_unit;
  import sha256_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  class digest_scoreboard;
    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    logic [63:0]  nbits;
    int           fill;
    digest_beat_t pending [$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
      for (int i = 0; i < 16; i++) blk[i] = '0;
      nbits = '0;
      fill = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] v [8];
      logic [31:0] w [64];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
      for (int i = 0; i < 16; i++) blk[i] = '0;
    endfunction

    function void note_word(logic [31:0] data, logic [2:0] nb_in, logic fin);
      int nb;
      int pos;
      digest_beat_t b;
      if (!fin) begin
        blk[fill] = data;
        nbits += 32;
        fill = (fill + 1) % 16;
        if (fill == 0) compress();
        return;
      end
      nb = (nb_in > 4) ? 4 : nb_in;
      if (nb == 0) data = '0;
      else if (nb < 4) data &= 32'hffffffff << (32 - 8 * nb);
      blk[fill] = data;
      nbits += 8 * nb;
      pos = 4 * fill + nb;
      if (pos >= 64) begin
        compress();
        pos = 0;
      end
      blk[pos / 4] |= 32'(PAD_BYTE) << (24 - 8 * (pos % 4));
      if (pos >= 56) compress();
      blk[14] = nbits[63:32];
      blk[15] = nbits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        b.word = chain[i];
        b.idx = 3'(i);
        b.last = (i == 7);
        pending.push_back(b);
      end
      restart();
    endfunction

    function void check_beat(digest_beat_t got);
      digest_beat_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest beat %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("digest mismatch: exp word %h idx %0d last %0b, got word %h idx %0d last %0b",
                   exp.word, exp.idx, exp.last, got.word, got.idx, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // message_word
  logic [2:0]  s_axis_tuser;   // valid_bytes
  logic        s_axis_tlast;   // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // digest_word
  logic [2:0]  m_axis_tuser;   // word_index
  logic        m_axis_tlast;   // last_digest

  digest_scoreboard sb;
  bit  calm;
  int  cycles;
  int  words_sent;

  sha256_hash_engine_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Output side: check accepted beats and stall in random bursts.
  initial begin
    int gap;
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready && !rst)
        sb.check_beat({m_axis_tdata, m_axis_tuser, m_axis_tlast});
      if (gap > 0) begin
        gap--;
        m_axis_tready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9) - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Leave tvalid high after a transaction; the next call drops or refills it.
  task automatic send_word(logic [31:0] data, logic [2:0] nb, logic fin);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= nb;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(data, nb, fin);
    words_sent++;
  endtask

  // Message of n words; the final word carries the given byte count.
  task automatic send_message(int n, logic [2:0] nb, bit rnd);
    for (int i = 0; i < n - 1; i++)
      send_word(rnd ? $urandom : 32'hffffffff, 3'($urandom), 1'b0);
    send_word(rnd ? $urandom : 32'hffffffff, nb, 1'b1);
  endtask

  initial begin
    sb = new();
    calm = 0;
    words_sent = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty message, all-zero and all-one words, every byte count,
    // pad and length in a second block, last word filling the block.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd5, 1'b1);
    send_message(14, 3'd2, 1'b0);
    send_message(16, 3'd4, 1'b1);
    send_message(16, 3'd0, 1'b1);

    // Random messages, mostly short, a few spanning two blocks.
    while (words_sent < 95) begin
      if ($urandom_range(0, 7) == 0) send_message($urandom_range(17, 24), 3'($urandom), 1'b1);
      else send_message($urandom_range(1, 16), 3'($urandom), 1'b1);
      if (words_sent > 75) calm = 1;
    end
    s_axis_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ sha256_hash_engine_unit.f @@
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_ctrl.sv
rtl/sha256_hash_engine_unit.sv
tb/sv/tb_sha256_hash_engine_unit.sv
